/* design/sorted_block_entry_parser_core_assert.svh */
// Assertion macros for the sorted block entry parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SORTED_BLOCK_ENTRY_PARSER_CORE_ASSERT_SVH
`define SORTED_BLOCK_ENTRY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SBEP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/sbep_pkg.sv */
// Package for the sorted block entry parser: phase, kind and error codes,
// parser state and result structs. No dependencies.
package sbep_pkg;

   localparam int MaxVarintBytes = 5;

   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 80;
   localparam int RspUserWidth = 4;

   typedef enum logic [1:0] {
      PH_KLEN = 2'd0,
      PH_KEY  = 2'd1,
      PH_VLEN = 2'd2,
      PH_VAL  = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      KIND_KLEN    = 3'd0,
      KIND_KEY     = 3'd1,
      KIND_VLEN    = 3'd2,
      KIND_VAL     = 3'd3,
      KIND_IGNORED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_OK             = 3'd0,
      ERR_BAD_KLEN       = 3'd1,
      ERR_KEY_PAST_END   = 3'd2,
      ERR_BAD_VLEN       = 3'd3,
      ERR_VALUE_PAST_END = 3'd4
   } error_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] acc;
      logic [2:0]  vcount;
      logic [31:0] region_left;
      logic [31:0] field_left;
      logic [31:0] key_len;
      logic [31:0] vlen_saved;
      error_type   err;
   } state_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      kind_type    kind;
      logic        entry_done;
      logic [31:0] key_length;
      logic [31:0] value_length;
      error_type   error;
      logic        region_done;
   } result_type;

   localparam state_type StateReset = '{
      phase:       PH_KLEN,
      acc:         32'd0,
      vcount:      3'd0,
      region_left: 32'd0,
      field_left:  32'd0,
      key_len:     32'd0,
      vlen_saved:  32'd0,
      err:         ERR_OK
   };

endpackage

/* design/sbep_step.sv */
// Per-byte next-state and result logic of the sorted block entry parser.
// Depends on sbep_pkg.
module sbep_step
   import sbep_pkg::*;
(
   input  state_type   cur_state,
   input  logic [7:0]  data_byte,
   input  logic        block_start,
   input  logic [31:0] region_length,
   output state_type   nxt_state,
   output result_type  result
);

   state_type   s;
   result_type  res;
   logic [2:0]  cnt;
   logic [31:0] shifted;
   logic [31:0] len;
   logic [31:0] region_dec;
   logic        last;
   logic        field_end;

   always_comb begin
      s = cur_state;
      if (block_start) begin
         s = StateReset;
         s.region_left = region_length;
      end

      res.data_byte    = data_byte;
      res.kind         = KIND_IGNORED;
      res.entry_done   = 1'b0;
      res.region_done  = 1'b0;
      res.value_length = 32'd0;
      res.key_length   = 32'd0;
      res.error        = ERR_OK;

      region_dec = s.region_left - 32'd1;
      last       = (s.region_left == 32'd1);
      field_end  = (s.field_left <= 32'd1);
      cnt        = (s.vcount > 3'd4) ? 3'd4 : s.vcount;

      // place the seven payload bits of this varint byte; bits above 32 fall off
      unique case (cnt)
         3'd0:    shifted = {25'd0, data_byte[6:0]};
         3'd1:    shifted = {18'd0, data_byte[6:0], 7'd0};
         3'd2:    shifted = {11'd0, data_byte[6:0], 14'd0};
         3'd3:    shifted = {4'd0, data_byte[6:0], 21'd0};
         default: shifted = {data_byte[3:0], 28'd0};
      endcase
      len = s.acc | shifted;

      if (s.err == ERR_OK && s.region_left != 32'd0) begin
         s.region_left   = region_dec;
         res.region_done = last;
         res.kind        = kind_type'({1'b0, s.phase});
         unique case (s.phase)
            PH_KLEN, PH_VLEN: begin
               s.acc = len;
               if (data_byte[7]) begin
                  if (({1'b0, cnt} + 4'd1) >= 4'(MaxVarintBytes) || last) begin
                     s.err = (s.phase == PH_KLEN) ? ERR_BAD_KLEN : ERR_BAD_VLEN;
                     s.region_left = 32'd0;
                  end else begin
                     s.vcount = cnt + 3'd1;
                  end
               end else begin
                  s.acc    = 32'd0;
                  s.vcount = 3'd0;
                  // compare against the bytes left after this one
                  if (s.phase == PH_KLEN) begin
                     s.key_len = len;
                     if (len > s.region_left) begin
                        s.err = ERR_KEY_PAST_END;
                        s.region_left = 32'd0;
                     end else if (len == 32'd0) begin
                        if (last) begin
                           s.err = ERR_BAD_VLEN;
                           s.region_left = 32'd0;
                        end else begin
                           s.phase = PH_VLEN;
                        end
                     end else begin
                        s.phase      = PH_KEY;
                        s.field_left = len;
                     end
                  end else begin
                     s.vlen_saved = len;
                     if (len > s.region_left) begin
                        s.err = ERR_VALUE_PAST_END;
                        s.region_left = 32'd0;
                     end else if (len == 32'd0) begin
                        res.entry_done = 1'b1;
                     end else begin
                        s.phase      = PH_VAL;
                        s.field_left = len;
                     end
                  end
               end
            end
            PH_KEY: begin
               s.field_left = field_end ? 32'd0 : s.field_left - 32'd1;
               if (field_end) begin
                  if (last) begin
                     s.err = ERR_BAD_VLEN;
                     s.region_left = 32'd0;
                  end else begin
                     s.phase = PH_VLEN;
                  end
               end
            end
            default: begin
               s.field_left = field_end ? 32'd0 : s.field_left - 32'd1;
               res.entry_done = field_end;
            end
         endcase
      end

      res.key_length = s.key_len;
      if (res.entry_done) begin
         res.value_length = s.vlen_saved;
         s.phase      = PH_KLEN;
         s.key_len    = 32'd0;
         s.vlen_saved = 32'd0;
      end
      res.error = s.err;

      nxt_state = s;
      result    = res;
   end

endmodule

/* design/sorted_block_entry_parser_core.sv */
// Top level of the sorted block entry parser: stream ports and registers.
// Depends on sbep_pkg, sbep_step and sorted_block_entry_parser_core_assert.svh.
//
// Parses the entry region of a sorted storage block, one byte per transfer:
// each entry is a varint32 key length, the key, a varint32 value length and
// the value. Every byte comes back tagged with its role; the byte that ends an
// entry carries the decoded key and value lengths. A transfer with the
// block-start flag set begins a new block and loads the region length. Errors
// are sticky until the next block start, and bytes outside the region or
// after an error come back marked ignored. One byte is taken every clock cycle
// unless a result waits that the downstream side has not taken; the result
// sits in a one-deep output register that keeps accepting while the downstream
// side takes the previous result, and shows in the cycle after its byte is taken.
`include "sorted_block_entry_parser_core_assert.svh"

module sorted_block_entry_parser_core
   import sbep_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [7:0] data_byte, [39:8] region_length
   input  logic [ReqDataWidth-1:0] req_tdata,
   // [0] block_start
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [7:0] byte_out, [39:8] key_length, [71:40] value_length,
   // [74:72] error_code, [79:75] zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   // [2:0] byte_kind, [3] entry_done
   output logic [RspUserWidth-1:0] rsp_tuser,
   // region_done
   output logic                    rsp_tlast
);

   state_type  state_ff;
   state_type  state_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   sbep_step u_step (
      .cur_state     (state_ff),
      .data_byte     (req_tdata[7:0]),
      .block_start   (req_tuser),
      .region_length (req_tdata[39:8]),
      .nxt_state     (state_in),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         // refill on a transfer, drop when the result is taken with nothing behind it
         if (req_tready) begin
            rsp_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.error, rsp_ff.value_length, rsp_ff.key_length,
                        rsp_ff.data_byte};
   assign rsp_tuser  = {rsp_ff.entry_done, rsp_ff.kind};
   assign rsp_tlast  = rsp_ff.region_done;

   `SBEP_ASSERT_NEXT(a_accept_fills, clock, reset, accept, rsp_valid_ff, "accepted byte lost before the result register")
   `SBEP_ASSERT_NOW(a_done_kind, clock, reset, rsp_valid_ff && rsp_ff.entry_done, rsp_ff.kind == KIND_VLEN || rsp_ff.kind == KIND_VAL, "entry completed on a key byte")
   `SBEP_ASSERT_NOW(a_done_clean, clock, reset, rsp_valid_ff && rsp_ff.entry_done, rsp_ff.error == ERR_OK, "entry completed under an error")
   `SBEP_ASSERT_NOW(a_error_stops, clock, reset, state_ff.err != ERR_OK, state_ff.region_left == 32'd0, "error left region bytes outstanding")
   `SBEP_ASSERT_NOW(a_field_live, clock, reset, (state_ff.phase == PH_KEY || state_ff.phase == PH_VAL) && state_ff.err == ERR_OK && state_ff.region_left != 32'd0, state_ff.field_left != 32'd0, "key or value phase with no bytes left")

endmodule
